@@ hdl/sird_pkg.sv @@
// Shared types, constants and the digit table check for the radix digit writer.
package sird_pkg;

  // Field and register widths
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int BASE_W     = 5;
  localparam int SYM_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Parameter defaults
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int DIGIT_DEPTH_DEF = 32;

  // Division: quotient bits resolved per cycle and cycles per digit
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;
  localparam int STEP_W     = $clog2(DIV_CYCLES);

  // Characters with special meaning
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  // Register reset values
  localparam logic [BASE_W-1:0] BASE_SIZE_RST    = 5'd10;
  localparam logic [SYM_W-1:0]  SYMBOLS_LOW_RST  = 64'h3736353433323130;
  localparam logic [SYM_W-1:0]  SYMBOLS_HIGH_RST = 64'h0000000000003938;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SIZE    = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // take a new input transaction
    logic div;       // run one cycle of the divider
    logic push;      // store the finished digit, start the next one
    logic sign_out;  // load the minus sign into the output register
    logic emit;      // load the top digit symbol and pop it
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic table_ok;
    logic is_neg;
    logic quot_zero;
    logic count_full;
    logic last_digit;
    logic out_free;
  } status_t;

  // Digit table is usable: radix in range, no sign symbols, no repeats
  function automatic logic table_ok(input logic [2*SYM_W-1:0] syms,
                                    input logic [BASE_W-1:0]  n,
                                    input int                 max_sym);
    logic              ok;
    logic [CHAR_W-1:0] s;
    ok = (n >= BASE_W'(2)) && (int'(n) <= max_sym);
    for (int a = 0; a < 16; a++) begin
      s = syms[a*CHAR_W +: CHAR_W];
      if (a < int'(n)) begin
        if (s == CH_MINUS || s == CH_PLUS) ok = 1'b0;
        for (int b = a + 1; b < 16; b++) begin
          if (b < int'(n) && syms[b*CHAR_W +: CHAR_W] == s) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

@@ hdl/sird_dp.sv @@
// Datapath: configuration registers, digit divider, digit stack and output register.
module sird_dp #(
  parameter int MAX_SYMBOLS = sird_pkg::MAX_SYMBOLS_DEF,
  parameter int DIGIT_DEPTH = sird_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic signed [sird_pkg::VALUE_W-1:0] in_value,
  input  sird_pkg::cmd_t                    cmd,
  output sird_pkg::status_t                 status,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [sird_pkg::CHAR_W-1:0]       out_char_out,
  output logic                              out_last_char
);
  import sird_pkg::*;

  localparam int DW = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int RW = DW + 1;
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  logic [BASE_W-1:0] base_size_r;
  logic [SYM_W-1:0]  symbols_low_r;
  logic [SYM_W-1:0]  symbols_high_r;

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic               neg_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [DW-1:0]      stack_r [DIGIT_DEPTH];

  logic [VALUE_W-1:0] quot_div;
  logic [RW-1:0]      rem_div;
  logic [RW-1:0]      divisor;
  logic [VALUE_W-1:0] in_mag;

  logic [3:0]         sym_idx;
  logic [6:0]         sym_off;
  logic [2*SYM_W-1:0] sym_vec;
  logic [CHAR_W-1:0]  sym_char;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r    <= BASE_SIZE_RST;
      symbols_low_r  <= SYMBOLS_LOW_RST;
      symbols_high_r <= SYMBOLS_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_SIZE)    base_size_r    <= cfg_wdata[BASE_W-1:0];
      if (cfg_index == REG_SYMBOLS_LOW)  symbols_low_r  <= cfg_wdata;
      if (cfg_index == REG_SYMBOLS_HIGH) symbols_high_r <= cfg_wdata;
    end
  end

  assign sym_vec = {symbols_high_r, symbols_low_r};

  // Magnitude of the input, most negative value gives 2^31
  assign in_mag  = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                       : VALUE_W'(in_value);
  assign divisor = base_size_r[RW-1:0];

  // Restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    logic [RW-1:0]      r;
    logic [VALUE_W-1:0] q;
    r = rem_r;
    q = mag_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[RW-2:0], q[VALUE_W-1]};
      q = {q[VALUE_W-2:0], 1'b0};
      if (r >= divisor) begin
        r    = r - divisor;
        q[0] = 1'b1;
      end
    end
    rem_div  = r;
    quot_div = q;
  end

  // Dividend/quotient, remainder and digit count
  always_comb begin
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    count_nxt = count_r;
    if (cmd.load) begin
      mag_nxt   = in_mag;
      rem_nxt   = '0;
      count_nxt = '0;
    end else if (cmd.div) begin
      mag_nxt = quot_div;
      rem_nxt = cmd.push ? '0 : rem_div;
      if (cmd.push) count_nxt = count_r + CW'(1);
    end else if (cmd.emit) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    if (cmd.load) neg_r <= in_value[VALUE_W-1];
  end

  // Digit stack: push shifts down, pop shifts up, top is entry 0
  always_ff @(posedge clk) begin
    if (cmd.div && cmd.push) begin
      stack_r[0] <= rem_div[DW-1:0];
      for (int i = 1; i < DIGIT_DEPTH; i++) stack_r[i] <= stack_r[i-1];
    end else if (cmd.emit) begin
      for (int i = 0; i < DIGIT_DEPTH - 1; i++) stack_r[i] <= stack_r[i+1];
    end
  end

  // Symbol lookup for the top digit
  assign sym_idx  = 4'(stack_r[0]);
  assign sym_off  = {sym_idx, 3'b000};
  assign sym_char = sym_vec[sym_off +: CHAR_W];

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.sign_out || cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall)          out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sign_out) begin
      out_char_r <= CH_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit) begin
      out_char_r <= sym_char;
      out_last_r <= (count_r == CW'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

  // Status back to the controller
  assign status.table_ok   = table_ok(sym_vec, base_size_r, MAX_SYMBOLS);
  assign status.is_neg     = neg_r;
  assign status.quot_zero  = (quot_div == '0);
  assign status.count_full = (count_r == CW'(DIGIT_DEPTH - 1));
  assign status.last_digit = (count_r == CW'(1));
  assign status.out_free   = !out_valid_r || !out_stall;

  // Stack never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && count_r == CW'(DIGIT_DEPTH)))
    else $error("digit stack overflow");

  // Pop only with digits held
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (count_r != '0))
    else $error("digit stack underflow");

  // A waiting character is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.sign_out) |-> (!out_valid_r || !out_stall))
    else $error("output character overwritten while stalled");

endmodule

@@ hdl/sird_ctrl.sv @@
// Controller: sequences accept, table check, per-digit division and emission.
module sird_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output sird_pkg::cmd_t    cmd,
  input  sird_pkg::status_t status
);
  import sird_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_SIGN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                step_last;

  assign step_last = (step_r == STEP_W'(DIV_CYCLES - 1));

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        step_nxt  = '0;
        state_nxt = status.table_ok ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_last) begin
          cmd.push = 1'b1;
          step_nxt = '0;
          if (status.quot_zero || status.count_full) begin
            state_nxt = status.is_neg ? S_SIGN : S_EMIT;
          end
        end
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.sign_out = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_digit) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Inputs are taken only when idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("transaction loaded outside idle");

  // A rejected table returns straight to idle
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !status.table_ok) |=> (state_r == S_IDLE))
    else $error("invalid table not rejected");

  // A digit is stored only on the last step of a division
  a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (cmd.div && step_last))
    else $error("digit stored mid-division");

endmodule

@@ hdl/signed_integer_to_radix_digits.sv @@
// Operation: after acceptance the digit table is checked, then each digit is divided out with
// 8 quotient bits a cycle; the sign, if any, and the digits follow, one character per free cycle.
// A new value is taken only after the last character of the previous one has entered the output
// register; an unusable table returns straight to idle. Output stalls stretch the emission.
// Reset (synchronous, rst_n low): controller idle, output empty, base 10, symbols "0".."9".
// Top level: radix digit writer, controller plus datapath.
module signed_integer_to_radix_digits #(
  parameter int MAX_SYMBOLS = sird_pkg::MAX_SYMBOLS_DEF,
  parameter int DIGIT_DEPTH = sird_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sird_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sird_pkg::CHAR_W-1:0]         out_char_out,
  output logic                                out_last_char
);
  import sird_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  sird_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Registers, divider, digit stack, output stage
  sird_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_char_out  (out_char_out),
    .out_last_char (out_last_char)
  );

endmodule

@@ dv/signed_integer_to_radix_digits_tb.sv @@
// Self-checking testbench for the signed integer to radix digit writer.
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_tb;
  import sird_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  // Longest item: base 2, 32 digits divided out, then 33 characters out
  localparam int SETTLE_CYCLES  = 250;
  localparam int RANDOM_PHASES  = 8;
  localparam int ITEMS_PER_PHASE = 14;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } char_exp_t;

  // DUT connections, all inputs known from time zero
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CHAR_W-1:0]         out_char_out;
  logic                      out_last_char;

  // Shadow copy of the registers
  logic [BASE_W-1:0] radix_reg = BASE_SIZE_RST;
  logic [SYM_W-1:0]  sym_low_reg = SYMBOLS_LOW_RST;
  logic [SYM_W-1:0]  sym_high_reg = SYMBOLS_HIGH_RST;

  logic signed [VALUE_W-1:0] pending_values[$];
  char_exp_t                 expected_chars[$];
  char_exp_t                 exp_head;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int values_sent = 0;
  int chars_checked = 0;
  int settings_count = 0;
  int quiet_cycles = 0;

  signed_integer_to_radix_digits i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_last_char(out_last_char)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Table is usable when the radix is in range and the symbols in use are
  // distinct and free of sign characters
  function automatic bit table_usable(input int n);
    bit [255:0]         seen;
    logic [CHAR_W-1:0]  s;
    logic [2*SYM_W-1:0] syms;
    seen = '0;
    syms = {sym_high_reg, sym_low_reg};
    if (n < 2 || n > MAX_SYMBOLS_DEF) return 1'b0;
    for (int k = 0; k < n; k++) begin
      s = syms[k*CHAR_W +: CHAR_W];
      if (s == CH_MINUS || s == CH_PLUS || seen[s]) return 1'b0;
      seen[s] = 1'b1;
    end
    return 1'b1;
  endfunction

  // Expected characters of one value, most significant digit first
  function automatic void predict_chars(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rems[DIGIT_DEPTH_DEF];
    logic [VALUE_W-1:0] radix;
    logic [2*SYM_W-1:0] syms;
    int                 count;
    radix = VALUE_W'(radix_reg);
    syms = {sym_high_reg, sym_low_reg};
    count = 0;
    if (!table_usable(int'(radix_reg))) return;
    mag = v[VALUE_W-1] ? (32'd0 - $unsigned(v)) : $unsigned(v);
    do begin
      rems[count] = mag % radix;
      mag = mag / radix;
      count++;
    end while (mag != 0 && count < DIGIT_DEPTH_DEF);
    if (v[VALUE_W-1]) expected_chars.push_back('{char_code: CH_MINUS, is_last: 1'b0});
    for (int k = count - 1; k >= 0; k--) begin
      expected_chars.push_back('{char_code: syms[int'(rems[k][3:0])*CHAR_W +: CHAR_W],
                                 is_last: (k == 0)});
    end
  endfunction

  // Register write; the shadow follows since writes happen only while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_BASE_SIZE:    radix_reg = data[BASE_W-1:0];
      REG_SYMBOLS_LOW:  sym_low_reg = data;
      REG_SYMBOLS_HIGH: sym_high_reg = data;
      default: ;
    endcase
  endtask

  task automatic load_table(input logic [CFG_DATA_W-1:0] radix_word,
                            input logic [2*SYM_W-1:0] syms);
    write_reg(REG_BASE_SIZE, radix_word);
    write_reg(REG_SYMBOLS_LOW, syms[SYM_W-1:0]);
    write_reg(REG_SYMBOLS_HIGH, syms[2*SYM_W-1:SYM_W]);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 51; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 51; end
      IDLE_BOTH:     begin send_idle_pct = 21; stall_pct = 21; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Wait for every transaction to finish, then for the block to go quiet;
  // sampled at the falling edge so the clocked blocks have settled
  task automatic wait_drained();
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Run one value through a table that produces nothing
  task automatic dead_table(input logic [CFG_DATA_W-1:0] radix_word,
                            input logic [2*SYM_W-1:0] syms);
    load_table(radix_word, syms);
    pending_values.push_back(-32'sd5);
    wait_drained();
  endtask

  // n distinct symbols without sign characters; unused slots hold anything
  function automatic logic [2*SYM_W-1:0] random_table(input int n);
    logic [2*SYM_W-1:0] t;
    bit [255:0]         used;
    logic [CHAR_W-1:0]  s;
    t = {$urandom, $urandom, $urandom, $urandom};
    used = '0;
    for (int k = 0; k < n; k++) begin
      do s = CHAR_W'($urandom); while (used[s] || s == CH_MINUS || s == CH_PLUS);
      used[s] = 1'b1;
      t[k*CHAR_W +: CHAR_W] = s;
    end
    return t;
  endfunction

  // Mix of full range, small values, values near the extremes and shifted values of either sign
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = VALUE_W'($urandom_range(600)) - 32'd300;
      2: v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                               : 32'h8000_0000 + $urandom_range(3);
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  // Input driver: the transaction completes on valid and no stall
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_chars(in_value);
        values_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("Unexpected character %h, last_char %b", out_char_out, out_last_char);
          error_count++;
        end else begin
          exp_head = expected_chars.pop_front();
          if (out_char_out !== exp_head.char_code) begin
            $error("char_out: expected %h, got %h", exp_head.char_code, out_char_out);
            error_count++;
          end
          if (out_last_char !== exp_head.is_last) begin
            $error("last_char: expected %b, got %b", exp_head.is_last, out_last_char);
            error_count++;
          end
          chars_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [2*SYM_W-1:0] syms;
    int                 n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // Reset table, decimal: zero, single digits, carries, both extremes
    pending_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
                       32'sh7FFF_FFFF, 32'sh8000_0000};
    wait_drained();

    // Binary with a zero byte symbol; sign characters sit in unused slots
    load_table(64'd2, 128'h2D2B2D2B_2D2B2D2B_2D2B2D2B_2D2BFF00);
    pending_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1};
    wait_drained();

    // Full sixteen symbol table
    load_table(64'd16, 128'h807FF00F_AA5501FE_46454443_42413930);
    pending_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd256};
    wait_drained();

    // Minus sign just past the symbols in use; spare index must be ignored
    load_table(64'd3, 128'h0000002D_636261);
    write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    pending_values = '{-32'sd7, 32'sd8};
    wait_drained();

    // Tables that must produce nothing
    dead_table(64'd0, 128'h807FF00F_AA5501FE_46454443_42413930);
    dead_table(64'd1, 128'h807FF00F_AA5501FE_46454443_42413930);
    dead_table(64'd17, 128'h807FF00F_AA5501FE_46454443_42413930);
    dead_table(64'd31, 128'h807FF00F_AA5501FE_46454443_42413930);
    dead_table(64'd4, 128'h322B3130);
    dead_table(64'd4, 128'h2D323130);
    dead_table(64'd5, 128'h30_33323130);

    // Random phases: valid tables mostly, one broken table among them
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) n = 2;
      else if (p == 1) n = MAX_SYMBOLS_DEF;
      else n = $urandom_range(MAX_SYMBOLS_DEF, 2);
      if (p == RANDOM_PHASES / 2) begin
        syms = random_table(n);
        case ($urandom_range(2))
          0: syms[$urandom_range(n - 1)*CHAR_W +: CHAR_W] = $urandom_range(1) ? CH_MINUS
                                                                              : CH_PLUS;
          1: syms[(n - 1)*CHAR_W +: CHAR_W] = syms[$urandom_range(n - 2)*CHAR_W +: CHAR_W];
          default: n = $urandom_range(1) ? $urandom_range(1) : $urandom_range(31, 17);
        endcase
        load_table({$urandom, 27'($urandom), 5'(n)}, syms);
        repeat (4) pending_values.push_back(random_value());
        wait_drained();
        n = $urandom_range(MAX_SYMBOLS_DEF, 2);
      end
      set_idling(idle_mode_t'(p % 4));
      load_table({$urandom, 27'($urandom), 5'(n)}, random_table(n));
      repeat (ITEMS_PER_PHASE) pending_values.push_back(random_value());
      wait_drained();
    end

    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      error_count++;
    end
    $display("Ran %0d values through %0d register settings, %0d characters checked,",
             values_sent, settings_count, chars_checked);
    $display("radix 2 to 16 and unusable tables, with and without idling on both sides");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sird_pkg.sv
hdl/sird_dp.sv
hdl/sird_ctrl.sv
hdl/signed_integer_to_radix_digits.sv
dv/signed_integer_to_radix_digits_tb.sv
